>>> sv/lwf_pkg.sv
// ----------------------------------------------------------------------------
// lwf_pkg
// Types, mode codes, hold lengths, register map and drive table shared by
// the wall-follow controller and its decision logic.
// ----------------------------------------------------------------------------
package lwf_pkg;

   localparam int RangeWidth = 14;
   localparam int SqWidth    = 2 * RangeWidth;

   // mode codes
   localparam logic [2:0] MODE_READY       = 3'd0;
   localparam logic [2:0] MODE_FOLLOW      = 3'd1;
   localparam logic [2:0] MODE_AVOID_LEFT  = 3'd2;
   localparam logic [2:0] MODE_AVOID_RIGHT = 3'd3;
   localparam logic [2:0] MODE_TURN_LEFT   = 3'd4;
   localparam logic [2:0] MODE_TURN_RIGHT  = 3'd5;
   localparam logic [2:0] MODE_COLLISION   = 3'd6;

   // hold lengths in ticks
   localparam logic [2:0] HOLD_SIDE  = 3'd7;
   localparam logic [2:0] HOLD_FRONT = 3'd5;
   localparam logic [2:0] HOLD_WALL  = 3'd2;

   // register indexes
   localparam logic [2:0] REG_NEAR_COLLISION = 3'd0;
   localparam logic [2:0] REG_FRONT_EXTRA    = 3'd1;
   localparam logic [2:0] REG_FRONT_TURN     = 3'd2;
   localparam logic [2:0] REG_WALL_MIN       = 3'd3;
   localparam logic [2:0] REG_WALL_MAX       = 3'd4;

   // register reset values
   localparam logic [RangeWidth-1:0] NEAR_COLLISION_RST = 14'd200;
   localparam logic [RangeWidth-1:0] FRONT_EXTRA_RST    = 14'd150;
   localparam logic [RangeWidth-1:0] FRONT_TURN_RST     = 14'd500;
   localparam logic [RangeWidth-1:0] WALL_MIN_RST       = 14'd300;
   localparam logic [RangeWidth-1:0] WALL_MAX_RST       = 14'd500;
   localparam logic [SqWidth-1:0]    WALL_MIN_SQ_RST    = 28'd90000;
   localparam logic [SqWidth-1:0]    WALL_MAX_SQ_RST    = 28'd250000;

   typedef struct packed {
      logic                  scan_valid;
      logic                  follow_right;
      logic [RangeWidth-1:0] diag_range;
      logic [RangeWidth-1:0] left_range_2;
      logic [RangeWidth-1:0] left_range_1;
      logic [RangeWidth-1:0] left_range_0;
      logic [RangeWidth-1:0] front_range_2;
      logic [RangeWidth-1:0] front_range_1;
      logic [RangeWidth-1:0] front_range_0;
      logic [RangeWidth-1:0] right_range_2;
      logic [RangeWidth-1:0] right_range_1;
      logic [RangeWidth-1:0] right_range_0;
   } lwf_item_type;

   typedef struct packed {
      logic [RangeWidth-1:0] near_collision_mm;
      logic [RangeWidth-1:0] front_extra_mm;
      logic [RangeWidth-1:0] front_turn_mm;
      logic [SqWidth-1:0]    wall_min_sq;
      logic [SqWidth-1:0]    wall_max_sq;
   } lwf_cfg_type;

   typedef struct packed {
      logic [2:0] cur_mode;
      logic [2:0] reported_mode;
      logic [2:0] hold_count;
      logic       last_side;
   } lwf_state_type;

   typedef struct packed {
      logic [2:0]        hold_left;
      logic              mode_changed;
      logic signed [5:0] drive_turn;
      logic signed [6:0] drive_power;
      logic [2:0]        mode;
   } lwf_result_type;

   localparam int ResultWidth = $bits(lwf_result_type);

   function automatic logic signed [6:0] drive_power_of(input logic [2:0] mode);
      logic signed [6:0] power;
      case (mode)
         MODE_FOLLOW:      power = 7'sd50;
         MODE_AVOID_LEFT:  power = 7'sd30;
         MODE_AVOID_RIGHT: power = 7'sd30;
         MODE_COLLISION:   power = -7'sd30;
         default:          power = 7'sd0;
      endcase
      return power;
   endfunction

   function automatic logic signed [5:0] drive_turn_of(input logic [2:0] mode);
      logic signed [5:0] turn;
      case (mode)
         MODE_AVOID_LEFT:  turn = -6'sd30;
         MODE_AVOID_RIGHT: turn = 6'sd30;
         MODE_TURN_LEFT:   turn = 6'sd30;
         MODE_TURN_RIGHT:  turn = -6'sd30;
         default:          turn = 6'sd0;
      endcase
      return turn;
   endfunction

endpackage

>>> sv/laser_wall_follow_controller.sv
// ----------------------------------------------------------------------------
// laser_wall_follow_controller
// Wall-following mode controller: one item per control tick in, one result
// item per tick out, five range registers on an APB-style port.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while rsp_tready is high. Each item passes an
// input register, the decision logic (two 14x14 squares and the range
// compares) and a result register, from which its result is offered on
// rsp_tvalid. While a result waits on rsp_tready the block still takes one
// more item into its input register. The squared wall limits are computed
// when wall_min_mm or wall_max_mm is written.
// ----------------------------------------------------------------------------
module laser_wall_follow_controller (
   input  logic         clock,
   input  logic         reset,
   // right_range_0..2, front_range_0..2, left_range_0..2, diag_range,
   // 14 bits each, zero pad in [143:140]
   input  logic [143:0] req_tdata,
   // follow_right, scan_valid
   input  logic [1:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[2:0], drive_power[9:3], drive_turn[15:10], mode_changed[16],
   // hold_left[19:17], zero pad in [23:20]
   output logic [23:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int Rw = lwf_pkg::RangeWidth;

   lwf_pkg::lwf_item_type   item_ff;
   lwf_pkg::lwf_item_type   item_in;
   logic                    item_valid_ff;
   logic                    item_valid_in;
   lwf_pkg::lwf_state_type  state_ff;
   lwf_pkg::lwf_state_type  state_next;
   lwf_pkg::lwf_result_type result;
   lwf_pkg::lwf_result_type rsp_data_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   lwf_pkg::lwf_cfg_type    cfg;
   logic [Rw-1:0]           wall_min_ff;
   logic [Rw-1:0]           wall_max_ff;
   logic [Rw-1:0]           wdata;
   logic [2:0]              reg_index;
   logic                    cfg_write;
   logic                    req_accept;
   logic                    out_load;

   // configuration
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[4:2];
   assign wdata      = csr_pwdata[Rw-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg.near_collision_mm <= lwf_pkg::NEAR_COLLISION_RST;
         cfg.front_extra_mm    <= lwf_pkg::FRONT_EXTRA_RST;
         cfg.front_turn_mm     <= lwf_pkg::FRONT_TURN_RST;
         cfg.wall_min_sq       <= lwf_pkg::WALL_MIN_SQ_RST;
         cfg.wall_max_sq       <= lwf_pkg::WALL_MAX_SQ_RST;
         wall_min_ff           <= lwf_pkg::WALL_MIN_RST;
         wall_max_ff           <= lwf_pkg::WALL_MAX_RST;
      end else if (cfg_write) begin
         case (reg_index)
            lwf_pkg::REG_NEAR_COLLISION: cfg.near_collision_mm <= wdata;
            lwf_pkg::REG_FRONT_EXTRA:    cfg.front_extra_mm    <= wdata;
            lwf_pkg::REG_FRONT_TURN:     cfg.front_turn_mm     <= wdata;
            lwf_pkg::REG_WALL_MIN: begin
               wall_min_ff     <= wdata;
               cfg.wall_min_sq <= {{Rw{1'b0}}, wdata} * {{Rw{1'b0}}, wdata};
            end
            lwf_pkg::REG_WALL_MAX: begin
               wall_max_ff     <= wdata;
               cfg.wall_max_sq <= {{Rw{1'b0}}, wdata} * {{Rw{1'b0}}, wdata};
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         lwf_pkg::REG_NEAR_COLLISION: csr_prdata = {18'd0, cfg.near_collision_mm};
         lwf_pkg::REG_FRONT_EXTRA:    csr_prdata = {18'd0, cfg.front_extra_mm};
         lwf_pkg::REG_FRONT_TURN:     csr_prdata = {18'd0, cfg.front_turn_mm};
         lwf_pkg::REG_WALL_MIN:       csr_prdata = {18'd0, wall_min_ff};
         lwf_pkg::REG_WALL_MAX:       csr_prdata = {18'd0, wall_max_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // input register
   assign out_load   = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || out_load;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      item_in.right_range_0 = req_tdata[0*Rw +: Rw];
      item_in.right_range_1 = req_tdata[1*Rw +: Rw];
      item_in.right_range_2 = req_tdata[2*Rw +: Rw];
      item_in.front_range_0 = req_tdata[3*Rw +: Rw];
      item_in.front_range_1 = req_tdata[4*Rw +: Rw];
      item_in.front_range_2 = req_tdata[5*Rw +: Rw];
      item_in.left_range_0  = req_tdata[6*Rw +: Rw];
      item_in.left_range_1  = req_tdata[7*Rw +: Rw];
      item_in.left_range_2  = req_tdata[8*Rw +: Rw];
      item_in.diag_range    = req_tdata[9*Rw +: Rw];
      item_in.follow_right  = req_tuser[0];
      item_in.scan_valid    = req_tuser[1];
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (out_load) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
   end

   lwf_decide u_decide (
      .item       (item_ff),
      .cfg        (cfg),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result)
   );

   // controller state and result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cur_mode      <= lwf_pkg::MODE_READY;
         state_ff.reported_mode <= lwf_pkg::MODE_READY;
         state_ff.hold_count    <= 3'd0;
         state_ff.last_side     <= 1'b1;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (out_load) begin
            state_ff <= state_next;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24 - lwf_pkg::ResultWidth){1'b0}}, rsp_data_ff};

`ifndef SYNTHESIS
   a_reported_tracks_result: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_data_ff.mode == state_ff.reported_mode))
      else $error("reported mode differs from the result just loaded");

   a_side_change_hold: assert property (@(posedge clock) disable iff (reset)
      (out_load && (item_ff.follow_right != state_ff.last_side)) |=>
         (state_ff.hold_count == lwf_pkg::HOLD_SIDE && rsp_data_ff.mode_changed ==
          (rsp_data_ff.mode != $past(state_ff.reported_mode))))
      else $error("side change did not start a full hold");

   a_hold_countdown: assert property (@(posedge clock) disable iff (reset)
      (out_load && item_ff.follow_right == state_ff.last_side &&
       state_ff.hold_count != 3'd0 && state_ff.cur_mode != lwf_pkg::MODE_COLLISION)
         |=> (state_ff.hold_count == $past(state_ff.hold_count) - 3'd1 ||
              state_ff.cur_mode == lwf_pkg::MODE_COLLISION))
      else $error("hold count did not count down");

   a_state_held_when_idle: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(state_ff))
      else $error("controller state changed without an item");
`endif

endmodule

>>> sv/lwf_decide.sv
// ----------------------------------------------------------------------------
// lwf_decide
// Mode decision for one control tick: side change, collision, hold countdown,
// front obstacle and wall distance rules, plus the drive table lookup.
// ----------------------------------------------------------------------------
module lwf_decide (
   input  lwf_pkg::lwf_item_type   item,
   input  lwf_pkg::lwf_cfg_type    cfg,
   input  lwf_pkg::lwf_state_type  state,
   output lwf_pkg::lwf_state_type  state_next,
   output lwf_pkg::lwf_result_type result
);

   logic [lwf_pkg::RangeWidth:0]   front_limit;
   logic                           side_change;
   logic                           collision;
   logic                           front_block;
   logic [lwf_pkg::RangeWidth-1:0] side_range;
   logic [lwf_pkg::SqWidth-1:0]    diag_sq;
   logic [lwf_pkg::SqWidth-1:0]    side_sq;
   logic [lwf_pkg::SqWidth-1:0]    diff;
   logic                           diff_neg;
   logic [2:0]                     mode_next;

   assign front_limit = {1'b0, cfg.near_collision_mm} + {1'b0, cfg.front_extra_mm};
   assign side_change = item.follow_right != state.last_side;

   assign collision = item.scan_valid && (
      (item.right_range_0 < cfg.near_collision_mm) ||
      (item.right_range_1 < cfg.near_collision_mm) ||
      (item.right_range_2 < cfg.near_collision_mm) ||
      (item.left_range_0 < cfg.near_collision_mm) ||
      (item.left_range_1 < cfg.near_collision_mm) ||
      (item.left_range_2 < cfg.near_collision_mm) ||
      ({1'b0, item.front_range_0} < front_limit) ||
      ({1'b0, item.front_range_1} < front_limit) ||
      ({1'b0, item.front_range_2} < front_limit));

   assign front_block = (item.front_range_0 < cfg.front_turn_mm) ||
                        (item.front_range_1 < cfg.front_turn_mm) ||
                        (item.front_range_2 < cfg.front_turn_mm);

   // diag squared against side squared
   assign side_range = item.follow_right ? item.right_range_0 : item.left_range_2;
   assign diag_sq    = {{lwf_pkg::RangeWidth{1'b0}}, item.diag_range} *
                       {{lwf_pkg::RangeWidth{1'b0}}, item.diag_range};
   assign side_sq    = {{lwf_pkg::RangeWidth{1'b0}}, side_range} *
                       {{lwf_pkg::RangeWidth{1'b0}}, side_range};
   assign diff_neg   = diag_sq < side_sq;
   assign diff       = diag_sq - side_sq;

   always_comb begin
      state_next = state;
      if (side_change) begin
         state_next.last_side  = item.follow_right;
         state_next.cur_mode   = item.follow_right ? lwf_pkg::MODE_TURN_LEFT
                                                   : lwf_pkg::MODE_TURN_RIGHT;
         state_next.hold_count = lwf_pkg::HOLD_SIDE;
      end else if (collision) begin
         state_next.cur_mode = lwf_pkg::MODE_COLLISION;
      end else if (state.hold_count != 3'd0) begin
         state_next.hold_count = state.hold_count - 3'd1;
      end else if (item.scan_valid && front_block) begin
         state_next.cur_mode   = item.follow_right ? lwf_pkg::MODE_TURN_LEFT
                                                   : lwf_pkg::MODE_TURN_RIGHT;
         state_next.hold_count = lwf_pkg::HOLD_FRONT;
      end else if (item.scan_valid) begin
         if (diff_neg) begin
            state_next.cur_mode = lwf_pkg::MODE_FOLLOW;
         end else if (diff < cfg.wall_min_sq) begin
            state_next.cur_mode = item.follow_right ? lwf_pkg::MODE_AVOID_RIGHT
                                                    : lwf_pkg::MODE_AVOID_LEFT;
         end else if (diff > cfg.wall_max_sq) begin
            state_next.cur_mode = item.follow_right ? lwf_pkg::MODE_AVOID_LEFT
                                                    : lwf_pkg::MODE_AVOID_RIGHT;
         end else begin
            state_next.cur_mode = lwf_pkg::MODE_FOLLOW;
         end
         state_next.hold_count = lwf_pkg::HOLD_WALL;
      end
      state_next.reported_mode = state_next.cur_mode;
   end

   assign mode_next = state_next.cur_mode;

   always_comb begin
      result.mode         = mode_next;
      result.drive_power  = lwf_pkg::drive_power_of(mode_next);
      result.drive_turn   = lwf_pkg::drive_turn_of(mode_next);
      result.mode_changed = mode_next != state.reported_mode;
      result.hold_left    = state_next.hold_count;
   end

endmodule
